### rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character constants and helpers for the JSON string escape
// encoder.
// ----------------------------------------------------------------------------
package jse_pkg;

	// characters used by the encoding
	localparam logic [7:0] QUOTE_CH  = 8'h22;
	localparam logic [7:0] BSLASH_CH = 8'h5C;
	localparam logic [7:0] SLASH_CH  = 8'h2F;
	localparam logic [7:0] BS_CH     = 8'h08;
	localparam logic [7:0] FF_CH     = 8'h0C;
	localparam logic [7:0] LF_CH     = 8'h0A;
	localparam logic [7:0] CR_CH     = 8'h0D;
	localparam logic [7:0] TAB_CH    = 8'h09;
	localparam logic [7:0] ESC_B_CH  = 8'h62;
	localparam logic [7:0] ESC_F_CH  = 8'h66;
	localparam logic [7:0] ESC_N_CH  = 8'h6E;
	localparam logic [7:0] ESC_R_CH  = 8'h72;
	localparam logic [7:0] ESC_T_CH  = 8'h74;
	localparam logic [7:0] ESC_U_CH  = 8'h75;
	localparam logic [7:0] ZERO_CH   = 8'h30;
	localparam logic [7:0] LOWER_A_CH = 8'h61;
	localparam logic [7:0] PRINT_LO  = 8'd32;
	localparam logic [7:0] PRINT_HI  = 8'd126;

	// body length of each kind of encoding
	localparam logic [3:0] LEN_PLAIN = 4'd1;
	localparam logic [3:0] LEN_SHORT = 4'd2;
	localparam logic [3:0] LEN_UNI   = 4'd6;

	// positions inside a unicode escape body
	localparam logic [2:0] UNI_BSLASH = 3'd0;
	localparam logic [2:0] UNI_U      = 3'd1;
	localparam logic [2:0] UNI_ZERO0  = 3'd2;
	localparam logic [2:0] UNI_ZERO1  = 3'd3;
	localparam logic [2:0] UNI_HEX_HI = 3'd4;

	typedef enum logic [1:0] {
		KIND_PLAIN = 2'd0,   // byte passes through
		KIND_SHORT = 2'd1,   // backslash plus one character
		KIND_UNI   = 2'd2    // backslash-u 00 plus two hex digits
	} kind_t;

	// one classified item as queued between front and back
	typedef struct packed {
		logic [7:0] chr;       // raw byte, or escape character for short kind
		kind_t      kind;
		logic       open;      // opening quote first
		logic       close;     // closing quote last
		logic [2:0] last_pos;  // index of the final byte of the run
	} desc_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		if (nib < 4'd10) begin
			d = ZERO_CH + {4'd0, nib};
		end else begin
			d = LOWER_A_CH + {4'd0, nib} - 8'd10;
		end
		return d;
	endfunction

endpackage

### rtl/jse_if.sv
// ----------------------------------------------------------------------------
// jse_if
// Valid/ready channels of the JSON string escape encoder.
// ----------------------------------------------------------------------------
interface jse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       first_byte;
	logic       last_byte;
	logic       empty_string;

	modport source (output valid, in_byte, first_byte, last_byte, empty_string,
		input ready);
	modport sink (input valid, in_byte, first_byte, last_byte, empty_string,
		output ready);
endinterface

interface jse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;

	modport source (output valid, out_byte, run_last, string_end, input ready);
	modport sink (input valid, out_byte, run_last, string_end, output ready);
endinterface

### rtl/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Accepts input transfers and classifies each byte into a run descriptor.
// ----------------------------------------------------------------------------
module jse_front (
	jse_in_if.sink          in,
	input  logic            q_full,
	output logic            push,
	output jse_pkg::desc_t  push_desc
);

	logic [7:0]     esc_chr;
	logic           is_short;
	logic           is_print;
	jse_pkg::kind_t kind;
	logic [3:0]     body_len;
	logic [3:0]     run_len;
	logic           open;
	logic           close;

	assign in.ready = !q_full;
	assign push     = in.valid && !q_full;

	always_comb begin
		is_short = 1'b1;
		esc_chr  = in.in_byte;
		unique case (in.in_byte)
			jse_pkg::QUOTE_CH:  esc_chr = jse_pkg::QUOTE_CH;
			jse_pkg::BSLASH_CH: esc_chr = jse_pkg::BSLASH_CH;
			jse_pkg::SLASH_CH:  esc_chr = jse_pkg::SLASH_CH;
			jse_pkg::BS_CH:     esc_chr = jse_pkg::ESC_B_CH;
			jse_pkg::FF_CH:     esc_chr = jse_pkg::ESC_F_CH;
			jse_pkg::LF_CH:     esc_chr = jse_pkg::ESC_N_CH;
			jse_pkg::CR_CH:     esc_chr = jse_pkg::ESC_R_CH;
			jse_pkg::TAB_CH:    esc_chr = jse_pkg::ESC_T_CH;
			default:            is_short = 1'b0;
		endcase
	end

	assign is_print = (in.in_byte >= jse_pkg::PRINT_LO) && (in.in_byte <= jse_pkg::PRINT_HI);

	always_comb begin
		priority if (in.empty_string) begin
			kind     = jse_pkg::KIND_PLAIN;
			body_len = 4'd0;
		end else if (is_short) begin
			kind     = jse_pkg::KIND_SHORT;
			body_len = jse_pkg::LEN_SHORT;
		end else if (is_print) begin
			kind     = jse_pkg::KIND_PLAIN;
			body_len = jse_pkg::LEN_PLAIN;
		end else begin
			kind     = jse_pkg::KIND_UNI;
			body_len = jse_pkg::LEN_UNI;
		end
	end

	// empty string is just the two quotes
	assign open    = in.first_byte || in.empty_string;
	assign close   = in.last_byte || in.empty_string;
	assign run_len = body_len + {3'd0, open} + {3'd0, close};

	assign push_desc.chr      = esc_chr;
	assign push_desc.kind     = kind;
	assign push_desc.open     = open;
	assign push_desc.close    = close;
	assign push_desc.last_pos = 3'(run_len - 4'd1);

endmodule

### rtl/jse_fifo.sv
// ----------------------------------------------------------------------------
// jse_fifo
// Short descriptor queue between the classifying front and the serializer.
// ----------------------------------------------------------------------------
module jse_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jse_pkg::desc_t push_desc,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output jse_pkg::desc_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	jse_pkg::desc_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Serializes one queued descriptor into its run of output bytes, one per
// cycle while the output is ready, into a registered output.
// ----------------------------------------------------------------------------
module jse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  jse_pkg::desc_t head,
	output logic           pop,
	jse_out_if.source      out
);

	logic [2:0] pos_q;
	logic [2:0] body_idx;
	logic       at_last;
	logic       fire;
	logic [7:0] byte_d;
	logic       end_d;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       string_end_q;

	assign fire     = q_valid && (!valid_q || out.ready);
	assign at_last  = (pos_q == head.last_pos);
	assign pop      = fire && at_last;
	assign body_idx = pos_q - {2'd0, head.open};

	always_comb begin
		end_d  = 1'b0;
		byte_d = head.chr;
		priority if (head.open && pos_q == 3'd0) begin
			byte_d = jse_pkg::QUOTE_CH;
		end else if (head.close && at_last) begin
			byte_d = jse_pkg::QUOTE_CH;
			end_d  = 1'b1;
		end else begin
			unique case (head.kind)
				jse_pkg::KIND_SHORT: begin
					byte_d = (body_idx == 3'd0) ? jse_pkg::BSLASH_CH : head.chr;
				end
				jse_pkg::KIND_UNI: begin
					unique case (body_idx)
						jse_pkg::UNI_BSLASH: byte_d = jse_pkg::BSLASH_CH;
						jse_pkg::UNI_U:      byte_d = jse_pkg::ESC_U_CH;
						jse_pkg::UNI_ZERO0:  byte_d = jse_pkg::ZERO_CH;
						jse_pkg::UNI_ZERO1:  byte_d = jse_pkg::ZERO_CH;
						jse_pkg::UNI_HEX_HI: byte_d = jse_pkg::hex_digit(head.chr[7:4]);
						default:             byte_d = jse_pkg::hex_digit(head.chr[3:0]);
					endcase
				end
				default: byte_d = head.chr;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				valid_q <= 1'b1;
				pos_q   <= at_last ? 3'd0 : pos_q + 3'd1;
			end else if (out.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q       <= byte_d;
			run_last_q   <= at_last;
			string_end_q <= end_d;
		end
	end

	assign out.valid      = valid_q;
	assign out.out_byte   = byte_q;
	assign out.run_last   = run_last_q;
	assign out.string_end = string_end_q;

endmodule

### rtl/json_string_escape_encoder_core.sv
// ----------------------------------------------------------------------------
// json_string_escape_encoder_core
// JSON string escape encoder: raw string bytes in, quoted JSON text out.
// ----------------------------------------------------------------------------
// Each input transfer carries one raw byte plus first/last/empty flags and
// yields a run of one to eight output bytes: an opening quote on the first
// byte, the byte itself or its escape (two bytes for quote, backslash, slash
// and the five control escapes, six bytes of backslash-u 00 xx for all other
// bytes outside 32..126), then a closing quote on the last byte. run_last
// marks the final byte of each run, string_end marks the closing quote.
// One output byte leaves per cycle while the output is ready, and plain
// bytes with no quote stream at one transfer per cycle unless it stalls.
// The back end serializer sets the output rate; a QUEUE_DEPTH entry
// descriptor queue lets the input keep flowing while the back end is busy
// or the output is stalled. A byte is written into the queue, then its run
// into the output register; the run counter is the only other state.
// ----------------------------------------------------------------------------
module json_string_escape_encoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	jse_in_if.sink     in,
	jse_out_if.source  out
);

	// front to queue
	logic           push;
	jse_pkg::desc_t push_desc;
	logic           q_full;

	// queue to back
	logic           q_valid;
	logic           pop;
	jse_pkg::desc_t head;

	// classify the byte and work out the run length
	jse_front u_front (
		.in        (in),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	// decouples input acceptance from output serialization
	jse_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head)
	);

	// walk the run one byte per transfer
	jse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.out     (out)
	);

endmodule
